[rtl/core/wsd_pkg.sv]
// Shared types and codes for the WebSocket frame deframer.
// Holds the result record, the status codes and the frame kind codes.
// No dependencies.
`default_nettype none

package wsd_pkg;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_CHUNK_DONE = 4'd1,
    ST_NEED_MORE  = 4'd2,
    ST_EMPTY      = 4'd3,
    ST_UNMASKED   = 4'd4,
    ST_OVERSIZE   = 4'd5,
    ST_BINARY     = 4'd6,
    ST_CLOSE      = 4'd7,
    ST_UNKNOWN    = 4'd8
  } wsd_status_t;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_PING = 2'd1,
    KIND_PONG = 2'd2
  } wsd_kind_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    wsd_kind_t   frame_kind;
    logic        message_final;
    logic        frame_end;
    wsd_status_t status;
  } wsd_result_t;

endpackage

`default_nettype wire

[rtl/core/wsd_parser.sv]
// Header parser, mask key capture and payload unmasking for one byte per step.
// Holds the frame state; the result of a step is combinational on its inputs.
// Depends on wsd_pkg.
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        chunk_end,
  output logic             res_valid,
  output wsd_result_t      res
);

  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_HDR1    = 4'd1,
    PH_EXT_HI  = 4'd2,
    PH_EXT_LO  = 4'd3,
    PH_KEY0    = 4'd4,
    PH_KEY1    = 4'd5,
    PH_KEY2    = 4'd6,
    PH_KEY3    = 4'd7,
    PH_PAYLOAD = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  wsd_kind_t   kind_reg, kind_next;
  logic        fin_reg, fin_next;
  logic        mask_flag, mask_flag_next;
  logic [15:0] payload_len, payload_len_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic        halted;

  logic [3:0]  opcode;
  logic [6:0]  len7;
  logic [15:0] count_inc;
  logic [15:0] len_lo;
  logic [7:0]  key_byte;
  logic [7:0]  data;
  logic        valid;
  logic        fend;
  logic        halt;
  wsd_status_t halt_code;
  wsd_status_t st;

  assign opcode    = rx_byte[3:0];
  assign len7      = rx_byte[6:0];
  assign count_inc = byte_count + 16'd1;
  assign len_lo    = payload_len | {8'd0, rx_byte};

  always_comb begin
    case (byte_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next       = phase;
    kind_next        = kind_reg;
    fin_next         = fin_reg;
    mask_flag_next   = mask_flag;
    payload_len_next = payload_len;
    byte_count_next  = byte_count;
    mask_key_next    = mask_key;
    data             = 8'd0;
    valid            = 1'b0;
    fend             = 1'b0;
    halt             = 1'b0;
    halt_code        = ST_OK;
    case (phase)
      PH_HDR0: begin
        fin_next  = rx_byte[7];
        kind_next = KIND_TEXT;
        if (opcode == OP_CONT || opcode == OP_TEXT) begin
          kind_next = KIND_TEXT;
        end else if (opcode == OP_BINARY) begin
          halt      = 1'b1;
          halt_code = ST_BINARY;
        end else if (opcode == OP_CLOSE) begin
          halt      = 1'b1;
          halt_code = ST_CLOSE;
        end else if (rx_byte[7] && opcode == OP_PING) begin
          kind_next = KIND_PING;
        end else if (rx_byte[7] && opcode == OP_PONG) begin
          kind_next = KIND_PONG;
        end else begin
          halt      = 1'b1;
          halt_code = ST_UNKNOWN;
        end
        if (!halt) begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        mask_flag_next = rx_byte[7];
        if (kind_reg == KIND_TEXT && len7 == 7'd0) begin
          halt      = 1'b1;
          halt_code = ST_EMPTY;
        end else if (len7 == LEN_EXT64) begin
          halt      = 1'b1;
          halt_code = ST_OVERSIZE;
        end else if (kind_reg == KIND_TEXT && !rx_byte[7]) begin
          halt      = 1'b1;
          halt_code = ST_UNMASKED;
        end else if (len7 == LEN_EXT16) begin
          phase_next = PH_EXT_HI;
        end else begin
          payload_len_next = {9'd0, len7};
          byte_count_next  = 16'd0;
          if (kind_reg == KIND_TEXT) begin
            phase_next = PH_KEY0;
          end else if (len7 == 7'd0) begin
            phase_next = PH_HDR0;
            fend       = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_EXT_HI: begin
        payload_len_next = {rx_byte, 8'd0};
        phase_next       = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        payload_len_next = len_lo;
        byte_count_next  = 16'd0;
        if (kind_reg == KIND_TEXT) begin
          phase_next = PH_KEY0;
        end else if (len_lo == 16'd0) begin
          phase_next = PH_HDR0;
          fend       = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_KEY0, PH_KEY1, PH_KEY2: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        phase_next    = phase_t'(phase + 4'd1);
      end
      PH_KEY3: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (payload_len == 16'd0) begin
          phase_next = PH_HDR0;
          fend       = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        data            = (kind_reg == KIND_TEXT) ? (rx_byte ^ key_byte) : rx_byte;
        valid           = 1'b1;
        byte_count_next = count_inc;
        if (count_inc == payload_len) begin
          fend       = 1'b1;
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
  end

  always_comb begin
    if (halt) begin
      st = halt_code;
    end else if (chunk_end) begin
      st = (phase_next == PH_HDR0) ? ST_CHUNK_DONE : ST_NEED_MORE;
    end else begin
      st = ST_OK;
    end
  end

  assign res_valid         = step && !halted && (halt || valid || fend || chunk_end);
  assign res.data_byte     = data;
  assign res.byte_valid    = valid;
  assign res.frame_kind    = kind_next;
  assign res.message_final = fin_next;
  assign res.frame_end     = fend;
  assign res.status        = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      kind_reg    <= KIND_TEXT;
      fin_reg     <= 1'b0;
      mask_flag   <= 1'b0;
      payload_len <= 16'd0;
      byte_count  <= 16'd0;
      mask_key    <= 32'd0;
      halted      <= 1'b0;
    end else if (step && !halted) begin
      kind_reg    <= kind_next;
      fin_reg     <= fin_next;
      mask_flag   <= mask_flag_next;
      payload_len <= payload_len_next;
      byte_count  <= byte_count_next;
      mask_key    <= mask_key_next;
      if (halt) begin
        halted <= 1'b1;
      end else begin
        phase <= phase_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/websocket_frame_deframer.sv]
// Path: an accepted input beat is held in the input register, and its result in the result register.
// Throughput: one input beat per cycle; the input register and the result
// register both advance whenever the result register is empty or being taken.
// Reset: synchronous, active high; the parser returns to the first header byte
// and clears a halt, and both registers empty.
`default_nettype none

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  wire logic        s_tlast,   // chunk_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // data_byte[7:0], status[11:8], zero[15:12]
  output logic [3:0]       m_tuser,   // byte_valid[0], frame_kind[2:1], message_final[3]
  output logic             m_tlast    // frame_end
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_ce;
  logic        advance;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_ce   <= s_tlast;
    end
  end

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .chunk_end (in_ce),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'd0, out_res.status, out_res.data_byte};
  assign m_tuser = {out_res.message_final, out_res.frame_kind, out_res.byte_valid};
  assign m_tlast = out_res.frame_end;

endmodule

`default_nettype wire

[tb/websocket_frame_deframer_checker.sv]
// Checker for the WebSocket frame deframer: watches both stream channels, predicts
// each result beat from the accepted input beats and compares it field by field.
// Depends on wsd_pkg for the result record, status and frame kind codes.
module websocket_frame_deframer_checker
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tlast,   // chunk_end
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // data_byte[7:0], status[11:8], zero[15:12]
  input  logic [3:0]  m_tuser,   // byte_valid[0], frame_kind[2:1], message_final[3]
  input  logic        m_tlast,   // frame_end
  output int          mismatch_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    AWAIT_HEAD, AWAIT_LEN, EXT_HIGH, EXT_LOW,
    KEY_0, KEY_1, KEY_2, KEY_3, IN_PAYLOAD
  } parse_step_t;

  parse_step_t  step;
  wsd_kind_t    cur_kind;
  logic         cur_fin;
  logic         masked;
  logic [15:0]  len_total;
  logic [15:0]  len_seen;
  logic [31:0]  key_word;
  logic         stopped;
  wsd_result_t  results_due[$];

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < 40) begin
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
               got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // The length is known: text frames go on to the mask key, control frames
  // to their payload, or end at once when empty.
  function automatic logic enter_body();
    len_seen = '0;
    if (cur_kind == KIND_TEXT) begin
      step = KEY_0;
      return 1'b0;
    end
    if (len_total == 16'd0) begin
      step = AWAIT_HEAD;
      return 1'b1;
    end
    step = IN_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic logic decode_byte(input logic [7:0] b, input logic ce,
                                       output wsd_result_t res);
    logic [3:0]  op;
    logic [6:0]  len7;
    logic [7:0]  dbyte;
    logic        vld;
    logic        fend;
    wsd_status_t halt;
    wsd_status_t st;
    res = '0;
    dbyte = 8'd0;
    vld = 1'b0;
    fend = 1'b0;
    halt = ST_OK;
    if (stopped) begin
      return 1'b0;
    end
    case (step)
      AWAIT_HEAD: begin
        cur_fin = b[7];
        op = b[3:0];
        cur_kind = KIND_TEXT;
        if (op == OP_CONT || op == OP_TEXT) begin
          cur_kind = KIND_TEXT;
        end else if (op == OP_BINARY) begin
          halt = ST_BINARY;
        end else if (op == OP_CLOSE) begin
          halt = ST_CLOSE;
        end else if (cur_fin && op == OP_PING) begin
          cur_kind = KIND_PING;
        end else if (cur_fin && op == OP_PONG) begin
          cur_kind = KIND_PONG;
        end else begin
          halt = ST_UNKNOWN;
        end
        if (halt == ST_OK) begin
          step = AWAIT_LEN;
        end
      end
      AWAIT_LEN: begin
        len7 = b[6:0];
        masked = b[7];
        if (cur_kind == KIND_TEXT && len7 == 7'd0) begin
          halt = ST_EMPTY;
        end else if (len7 == LEN_EXT64) begin
          halt = ST_OVERSIZE;
        end else if (cur_kind == KIND_TEXT && !masked) begin
          halt = ST_UNMASKED;
        end else if (len7 == LEN_EXT16) begin
          step = EXT_HIGH;
        end else begin
          len_total = {9'd0, len7};
          fend = enter_body();
        end
      end
      EXT_HIGH: begin
        len_total = {b, 8'h00};
        step = EXT_LOW;
      end
      EXT_LOW: begin
        len_total = {len_total[15:8], b};
        fend = enter_body();
      end
      KEY_0, KEY_1, KEY_2, KEY_3: begin
        key_word = {key_word[23:0], b};
        if (step == KEY_3) begin
          if (len_total == 16'd0) begin
            step = AWAIT_HEAD;
            fend = 1'b1;
          end else begin
            step = IN_PAYLOAD;
          end
        end else begin
          step = step.next();
        end
      end
      IN_PAYLOAD: begin
        dbyte = b;
        if (cur_kind == KIND_TEXT) begin
          dbyte = b ^ key_word[8 * (3 - len_seen[1:0]) +: 8];
        end
        vld = 1'b1;
        len_seen = len_seen + 16'd1;
        if (len_seen == len_total) begin
          fend = 1'b1;
          step = AWAIT_HEAD;
        end
      end
      default: begin
        step = AWAIT_HEAD;
      end
    endcase
    if (halt != ST_OK) begin
      stopped = 1'b1;
      st = halt;
    end else if (vld || fend || ce) begin
      if (!ce) begin
        st = ST_OK;
      end else if (step == AWAIT_HEAD) begin
        st = ST_CHUNK_DONE;
      end else begin
        st = ST_NEED_MORE;
      end
    end else begin
      return 1'b0;
    end
    res.data_byte = dbyte;
    res.byte_valid = vld;
    res.frame_kind = cur_kind;
    res.message_final = cur_fin;
    res.frame_end = fend;
    res.status = st;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    wsd_result_t got;
    wsd_result_t want;
    if (rst) begin
      step = AWAIT_HEAD;
      cur_kind = KIND_TEXT;
      cur_fin = 1'b0;
      masked = 1'b0;
      len_total = '0;
      len_seen = '0;
      key_word = '0;
      stopped = 1'b0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.data_byte = m_tdata[7:0];
        got.status = wsd_status_t'(m_tdata[11:8]);
        got.byte_valid = m_tuser[0];
        got.frame_kind = wsd_kind_t'(m_tuser[2:1]);
        got.message_final = m_tuser[3];
        got.frame_end = m_tlast;
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result beat", got.data_byte, 8'h00);
        end else begin
          want = results_due.pop_front();
          check_field("data_byte", got.data_byte, want.data_byte);
          check_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
          check_field("frame_kind", 8'(got.frame_kind), 8'(want.frame_kind));
          check_field("message_final", 8'(got.message_final), 8'(want.message_final));
          check_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
          check_field("status", 8'(got.status), 8'(want.status));
        end
      end
      if (s_tvalid && s_tready) begin
        if (decode_byte(s_tdata, s_tlast, want)) begin
          results_due.push_back(want);
        end
      end
    end
    results_pending = results_due.size();
  end

endmodule

[tb/websocket_frame_deframer_test.sv]
// Top of the WebSocket frame deframer testbench: clock, reset, frame stimulus,
// receiver stalls, watchdog and verdict. Depends on wsd_pkg, the deframer RTL
// and websocket_frame_deframer_checker, which predicts and compares results.
module websocket_frame_deframer_test
  import wsd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_BEATS = 1650;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  int          mismatch_count;
  int          results_pending;
  int          beats_sent;
  int          burst_left;
  int          idle_cycles;

  websocket_frame_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  websocket_frame_deframer_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic ce);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= ce;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_frame(input logic [3:0] op, input logic fin, input int len,
                            input logic use_ext, input logic mask_bit,
                            input logic [31:0] key, input int ce_pct);
    logic [15:0] len16;
    len16 = len[15:0];
    send_beat({fin, 3'($urandom_range(0, 7)), op}, chance(ce_pct));
    if (use_ext || len >= 126) begin
      send_beat({mask_bit, LEN_EXT16}, chance(ce_pct));
      send_beat(len16[15:8], chance(ce_pct));
      send_beat(len16[7:0], chance(ce_pct));
    end else begin
      send_beat({mask_bit, len16[6:0]}, chance(ce_pct));
    end
    if (op == OP_TEXT || op == OP_CONT) begin
      for (int i = 3; i >= 0; i--) begin
        send_beat(key[8 * i +: 8], chance(ce_pct));
      end
    end
    for (int i = 0; i < len; i++) begin
      send_beat(8'($urandom_range(0, 255)), chance(i == len - 1 ? 2 * ce_pct : ce_pct));
    end
  endtask

  task automatic send_random_frame();
    logic [3:0]  op;
    logic        fin;
    logic        is_text;
    logic        use_ext;
    logic [31:0] key;
    int          len;
    int          pick;
    int          ce_pct;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      op = OP_TEXT;
    end else if (pick < 6) begin
      op = OP_CONT;
    end else if (pick < 8) begin
      op = OP_PING;
    end else begin
      op = OP_PONG;
    end
    is_text = (op == OP_TEXT || op == OP_CONT);
    fin = is_text ? 1'($urandom_range(0, 1)) : 1'b1;
    use_ext = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      len = $urandom_range(1, 12);
    end else if (pick < 68) begin
      len = 0;
      use_ext = is_text || chance(50);
    end else if (pick < 80) begin
      len = $urandom_range(0, 125);
      use_ext = 1'b1;
    end else if (pick < 88) begin
      len = $urandom_range(13, 125);
    end else if (pick < 93) begin
      len = 125;
    end else begin
      len = $urandom_range(126, 400);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      key = 32'h0;
    end else if (pick == 1) begin
      key = 32'hFFFF_FFFF;
    end else begin
      key = $urandom();
    end
    case ($urandom_range(0, 3))
      0: ce_pct = 0;
      1: ce_pct = 5;
      2: ce_pct = 20;
      default: ce_pct = 50;
    endcase
    send_frame(op, fin, len, use_ext, is_text ? 1'b1 : 1'($urandom_range(0, 1)), key,
               ce_pct);
  endtask

  // One halting frame closes the run, since reset is applied only once.
  task automatic send_halting_frame();
    logic [3:0] op;
    logic [6:0] len7;
    case ($urandom_range(0, 7))
      0: begin
        send_beat({1'($urandom_range(0, 1)), 3'b000, OP_TEXT}, 1'b0);
        send_beat({1'($urandom_range(0, 1)), 7'd0}, chance(50));
      end
      1: begin
        len7 = 7'($urandom_range(1, 126));
        send_beat({1'b1, 3'b000, OP_CONT}, 1'b0);
        send_beat({1'b0, len7}, chance(50));
      end
      2: begin
        send_beat({1'b1, 3'b000, OP_TEXT}, 1'b0);
        send_beat({1'($urandom_range(0, 1)), LEN_EXT64}, chance(50));
      end
      3: begin
        send_beat({1'b1, 3'b000, $urandom_range(0, 1) ? OP_PING : OP_PONG}, 1'b0);
        send_beat({1'($urandom_range(0, 1)), LEN_EXT64}, chance(50));
      end
      4: send_beat({1'($urandom_range(0, 1)), 3'b000, OP_BINARY}, chance(50));
      5: send_beat({1'($urandom_range(0, 1)), 3'b000, OP_CLOSE}, chance(50));
      6: send_beat({1'b0, 3'b000, $urandom_range(0, 1) ? OP_PING : OP_PONG}, chance(50));
      default: begin
        do begin
          op = 4'($urandom_range(3, 15));
        end while (op == OP_CLOSE || op == OP_PING || op == OP_PONG);
        send_beat({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op}, chance(50));
      end
    endcase
    repeat (5) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int mode;
    int pattern_count;
    bit held;
    held = 1'b0;
    mode = 0;
    pattern_count = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      pattern_count++;
      if (pattern_count % 64 == 0) begin
        mode = $urandom_range(0, 3);
      end
      if (!held && beats_sent >= 400) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (pattern_count % 4 == 0);
          default: m_tready <= chance(90);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("websocket_frame_deframer_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    beats_sent = 0;
    burst_left = $urandom_range(1, 40);
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    s_tlast <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(OP_TEXT, 1'b1, 1, 1'b0, 1'b1, $urandom(), 0);
    send_frame(OP_TEXT, 1'b0, 4, 1'b0, 1'b1, 32'hFFFF_FFFF, 0);
    send_frame(OP_CONT, 1'b1, 5, 1'b0, 1'b1, 32'h0, 100);
    send_frame(OP_PING, 1'b1, 0, 1'b0, 1'b0, 32'h0, 0);
    send_frame(OP_PONG, 1'b1, 3, 1'b0, 1'b1, 32'h0, 0);
    send_frame(OP_TEXT, 1'b1, 0, 1'b1, 1'b1, $urandom(), 0);
    send_frame(OP_PING, 1'b1, 0, 1'b1, 1'b1, 32'h0, 100);
    send_frame(OP_TEXT, 1'b0, 2, 1'b0, 1'b1, $urandom(), 100);

    while (beats_sent < RANDOM_BEATS) begin
      send_random_frame();
    end
    send_halting_frame();
    s_tvalid <= 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("websocket_frame_deframer_test: PASS");
    end else begin
      $display("websocket_frame_deframer_test: FAIL");
    end
    $finish;
  end

endmodule
